[hdl/banked_memory_mapper_unit_macros.svh]
// Assertion macros for the banked memory mapper checker.
// Depends on nothing; included by the checker file.
`ifndef BANKED_MEMORY_MAPPER_UNIT_MACROS_SVH
`define BANKED_MEMORY_MAPPER_UNIT_MACROS_SVH

// implication checked outside reset
`define BMM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mapper check failed");

// next-cycle implication checked outside reset
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mapper check failed");

// next-cycle implication that also holds through reset
`define BMM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mapper check failed");

`endif

[hdl/bmm_pkg.sv]
// Shared types and constants for the banked memory mapper.
// No dependencies; imported by every mapper module.
package bmm_pkg;

   typedef enum logic [1:0] {
      TGT_ROM  = 2'd0,
      TGT_CART = 2'd1,
      TGT_SYS  = 2'd2,
      TGT_DROP = 2'd3
   } target_type;

   localparam logic [15:0] ADDR_CTRL  = 16'hFFFC;
   localparam logic [15:0] ADDR_SLOT0 = 16'hFFFD;
   localparam logic [15:0] ADDR_SLOT1 = 16'hFFFE;
   localparam logic [15:0] ADDR_SLOT2 = 16'hFFFF;

   localparam logic [1:0] PAGE_SLOT0 = 2'd0;
   localparam logic [1:0] PAGE_SLOT1 = 2'd1;
   localparam logic [1:0] PAGE_SLOT2 = 2'd2;

   localparam logic [7:0] BANK_MASK_RESET = 8'd15;

   localparam int CTRL_HALF_BIT = 2;
   localparam int CTRL_ON_BIT   = 3;

   typedef struct packed {
      logic        is_write;
      logic [15:0] cpu_addr;
      logic [7:0]  wr_byte;
   } req_type_s_type;

   typedef struct packed {
      target_type  target;
      logic [21:0] mem_addr;
      logic        write_enable;
      logic [7:0]  write_value;
   } rsp_type_s_type;

   typedef struct packed {
      logic [7:0] slot0;
      logic [7:0] slot1;
      logic [7:0] slot2;
      logic       cart_ram_half;
      logic       cart_ram_on;
   } map_state_type;

endpackage

[hdl/bmm_decode.sv]
// Address translation and control-register decode for one CPU access.
// Depends on bmm_pkg.
module bmm_decode (
   input  bmm_pkg::req_type_s_type req,
   input  bmm_pkg::map_state_type  state,
   input  logic [7:0]              bank_mask,
   output bmm_pkg::rsp_type_s_type rsp,
   output bmm_pkg::map_state_type  state_next
);
   import bmm_pkg::*;

   logic [15:0] a;
   logic [7:0]  v;
   logic [21:0] cart_addr;

   assign a = req.cpu_addr;
   assign v = req.wr_byte;
   assign cart_addr = {7'd0, state.cart_ram_half, a[13:0]};

   always_comb begin
      rsp = '0;
      rsp.target = TGT_DROP;
      state_next = state;
      if (!req.is_write) begin
         case (a[15:14])
            PAGE_SLOT0: begin
               rsp.target = TGT_ROM;
               if (a[13:10] == 4'd0) begin
                  rsp.mem_addr = {6'd0, a};
               end else begin
                  rsp.mem_addr = {state.slot0, a[13:0]};
               end
            end
            PAGE_SLOT1: begin
               rsp.target = TGT_ROM;
               rsp.mem_addr = {state.slot1, a[13:0]};
            end
            PAGE_SLOT2: begin
               if (state.cart_ram_on) begin
                  rsp.target = TGT_CART;
                  rsp.mem_addr = cart_addr;
               end else begin
                  rsp.target = TGT_ROM;
                  rsp.mem_addr = {state.slot2, a[13:0]};
               end
            end
            default: begin
               rsp.target = TGT_SYS;
               rsp.mem_addr = {9'd0, a[12:0]};
            end
         endcase
      end else begin
         case (a[15:14])
            PAGE_SLOT2: begin
               if (state.cart_ram_on) begin
                  rsp.target = TGT_CART;
                  rsp.mem_addr = cart_addr;
                  rsp.write_enable = 1'b1;
                  rsp.write_value = v;
               end
            end
            PAGE_SLOT0, PAGE_SLOT1: begin
               rsp.target = TGT_DROP;
            end
            default: begin
               rsp.target = TGT_SYS;
               rsp.mem_addr = {9'd0, a[12:0]};
               rsp.write_enable = 1'b1;
               rsp.write_value = v;
               case (a)
                  ADDR_CTRL: begin
                     state_next.cart_ram_half = v[CTRL_HALF_BIT];
                     state_next.cart_ram_on = v[CTRL_ON_BIT];
                  end
                  ADDR_SLOT0: state_next.slot0 = v & bank_mask;
                  ADDR_SLOT1: state_next.slot1 = v & bank_mask;
                  ADDR_SLOT2: state_next.slot2 = v & bank_mask;
                  default: ;
               endcase
            end
         endcase
      end
   end

endmodule

[hdl/banked_memory_mapper_unit.sv]
// Banked memory mapper: one CPU access per cycle in, one translated access per cycle out
// while rsp_tready stays high. Each word passes an input register and a result register;
// a stalled result holds the input register, which then deasserts req_tready. A control
// write at FFFC-FFFF changes the mapping from the very next word. Depends on bmm_pkg and
// bmm_decode.
module banked_memory_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cpu_addr[15:0], wr_byte[23:16]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // mem_addr[21:0], write_enable[22], write_value[30:23], 0
   output logic [1:0]  rsp_tuser,   // target
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);
   import bmm_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type_s_type in_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_type_s_type out_ff;
   map_state_type  state_ff, state_in;
   logic [7:0]     bank_mask_ff;
   rsp_type_s_type rsp;
   logic           advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   bmm_decode u_decode (
      .req        (in_ff),
      .state      (state_ff),
      .bank_mask  (bank_mask_ff),
      .rsp        (rsp),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
         bank_mask_ff <= BANK_MASK_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wen) begin
            bank_mask_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.is_write <= req_tuser;
         in_ff.cpu_addr <= req_tdata[15:0];
         in_ff.wr_byte <= req_tdata[23:16];
      end
      if (advance) begin
         out_ff <= rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_ff.target;
   assign rsp_tdata = {1'b0, out_ff.write_value, out_ff.write_enable, out_ff.mem_addr};

endmodule

[hdl/bmm_checker.sv]
// Port-level checks for the banked memory mapper, bound to the top level.
// Depends on bmm_pkg and banked_memory_mapper_unit_macros.svh.
`include "banked_memory_mapper_unit_macros.svh"

module bmm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import bmm_pkg::*;

   `BMM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)
   `BMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `BMM_ASSERT_IMPL(a_drop_zero, clock, reset, rsp_tvalid && rsp_tuser == TGT_DROP, rsp_tdata == 32'd0)
   `BMM_ASSERT_IMPL(a_we_target, clock, reset, rsp_tvalid && rsp_tdata[22], rsp_tuser == TGT_CART || rsp_tuser == TGT_SYS)
   `BMM_ASSERT_IMPL(a_sys_range, clock, reset, rsp_tvalid && rsp_tuser == TGT_SYS, rsp_tdata[21:13] == 9'd0)

endmodule

bind banked_memory_mapper_unit bmm_checker u_bmm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/banked_memory_mapper_unit_tb.sv]
// Self-checking testbench for banked_memory_mapper_unit: stream driver, result monitor, mapper
// model. Depends on bmm_pkg and the mapper RTL; needs no files or arguments.
module banked_memory_mapper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmm_pkg::*;

   localparam logic        KIND_READ   = 1'b0;
   localparam logic        KIND_WRITE  = 1'b1;
   localparam logic [15:0] FIXED_END   = 16'h0400;
   localparam logic [15:0] PAGE1_BASE  = 16'h4000;
   localparam logic [15:0] PAGE2_BASE  = 16'h8000;
   localparam logic [15:0] SYSRAM_BASE = 16'hC000;
   localparam int          WORDS_PER_SETTING = 180;

   typedef struct {
      logic        is_write;
      logic [15:0] cpu_addr;
      logic [7:0]  wr_byte;
   } cpu_access_type;

   typedef struct {
      target_type  tgt;
      logic [21:0] addr;
      logic        we;
      logic [7:0]  value;
   } mapped_access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // cpu_addr[15:0], wr_byte[23:16]
   logic        req_tuser = 1'b0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // mem_addr[21:0], write_enable[22], write_value[30:23], 0
   logic [1:0]  rsp_tuser;         // target
   logic        csr_wen = 1'b0;
   logic [7:0]  csr_wdata = '0;

   cpu_access_type    cpu_accesses_to_send[$];
   mapped_access_type expected_accesses[$];

   // mapper state as the testbench sees it
   logic [7:0] bank_mask_copy = BANK_MASK_RESET;
   logic [7:0] slot_bank[3] = '{8'd0, 8'd0, 8'd0};
   logic       ram_half = 1'b0;
   logic       ram_on = 1'b0;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int mismatches = 0;
   int results_checked = 0;
   int n_reads = 0, n_writes = 0, n_dropped = 0, n_cart = 0, n_ctrl = 0, n_masks = 0;

   banked_memory_mapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %0d at %0t: %s got %0h expected %0h", mismatches, $time, what, got,
               want);
      mismatches++;
   endtask

   // translate one CPU access; control writes update the mapping afterwards
   function automatic mapped_access_type map_access(logic is_write, logic [15:0] a,
                                                     logic [7:0] b);
      mapped_access_type m;
      m.tgt = TGT_DROP;
      m.addr = '0;
      m.we = 1'b0;
      m.value = '0;
      if (!is_write) begin
         n_reads++;
         if (a < FIXED_END) begin
            m.tgt = TGT_ROM;
            m.addr = {6'd0, a};
         end else if (a < PAGE1_BASE) begin
            m.tgt = TGT_ROM;
            m.addr = {slot_bank[0], a[13:0]};
         end else if (a < PAGE2_BASE) begin
            m.tgt = TGT_ROM;
            m.addr = {slot_bank[1], a[13:0]};
         end else if (a < SYSRAM_BASE) begin
            if (ram_on) begin
               m.tgt = TGT_CART;
               m.addr = {7'd0, ram_half, a[13:0]};
            end else begin
               m.tgt = TGT_ROM;
               m.addr = {slot_bank[2], a[13:0]};
            end
         end else begin
            m.tgt = TGT_SYS;
            m.addr = {9'd0, a[12:0]};
         end
      end else begin
         n_writes++;
         if (a >= PAGE2_BASE && a < SYSRAM_BASE && ram_on) begin
            m.tgt = TGT_CART;
            m.addr = {7'd0, ram_half, a[13:0]};
            m.we = 1'b1;
            m.value = b;
         end else if (a >= SYSRAM_BASE) begin
            m.tgt = TGT_SYS;
            m.addr = {9'd0, a[12:0]};
            m.we = 1'b1;
            m.value = b;
            if (a >= ADDR_CTRL) n_ctrl++;
            case (a)
               ADDR_CTRL: begin
                  ram_half = b[CTRL_HALF_BIT];
                  ram_on = b[CTRL_ON_BIT];
               end
               ADDR_SLOT0: slot_bank[PAGE_SLOT0] = b & bank_mask_copy;
               ADDR_SLOT1: slot_bank[PAGE_SLOT1] = b & bank_mask_copy;
               ADDR_SLOT2: slot_bank[PAGE_SLOT2] = b & bank_mask_copy;
               default: ;
            endcase
         end
         if (m.tgt == TGT_DROP) n_dropped++;
         if (m.tgt == TGT_CART) n_cart++;
      end
      return m;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      cpu_access_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_accesses.push_back(map_access(req_tuser, req_tdata[15:0],
                                                   req_tdata[23:16]));
         if (!req_tvalid || req_tready) begin
            if (cpu_accesses_to_send.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               w = cpu_accesses_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= w.is_write;
               req_tdata <= {w.wr_byte, w.cpu_addr};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin : check_results
      mapped_access_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_accesses.size() == 0) begin
            report_mismatch("unexpected result word", rsp_tdata, 0);
         end else begin
            e = expected_accesses.pop_front();
            results_checked++;
            if (rsp_tuser != e.tgt) report_mismatch("target", rsp_tuser, e.tgt);
            if (rsp_tdata[21:0] != e.addr) report_mismatch("mem_addr", rsp_tdata[21:0], e.addr);
            if (rsp_tdata[22] != e.we) report_mismatch("write_enable", rsp_tdata[22], e.we);
            if (rsp_tdata[30:23] != e.value)
               report_mismatch("write_value", rsp_tdata[30:23], e.value);
         end
      end
   end

   task automatic push_access(logic kind, logic [15:0] a, logic [7:0] b);
      cpu_access_type w;
      w.is_write = kind;
      w.cpu_addr = a;
      w.wr_byte = b;
      cpu_accesses_to_send.push_back(w);
   endtask

   // mostly plain traffic, with mapper control writes mixed in to keep the banks moving
   task automatic push_random_access();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 14)
         push_access(KIND_WRITE, ADDR_CTRL + 16'($urandom_range(0, 3)), 8'($urandom));
      else if (pick < 22)
         push_access(1'($urandom), 16'($urandom_range(0, 16'h03FF)), 8'($urandom));
      else if (pick < 40)
         push_access(1'($urandom), 16'($urandom_range(16'h8000, 16'hBFFF)), 8'($urandom));
      else
         push_access(1'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // sampled on the falling edge, once the driver and monitor have settled
   task automatic wait_until_drained();
      while (cpu_accesses_to_send.size() != 0 || req_tvalid || expected_accesses.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bank_mask(logic [7:0] v);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      bank_mask_copy = v;
      n_masks++;
   endtask

   initial begin : stimulus
      logic [7:0] masks[9];
      masks = '{8'h00, 8'hFF, 8'h3F, 8'($urandom), 8'h07, 8'hFF, 8'($urandom), 8'h01, 8'h0F};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: every region, dropped writes, fixed kilobyte, control registers
      push_access(KIND_READ,  16'h0000, 8'hFF);
      push_access(KIND_READ,  16'h03FF, 8'h00);
      push_access(KIND_READ,  16'h0400, 8'h00);
      push_access(KIND_READ,  16'h3FFF, 8'h00);
      push_access(KIND_READ,  16'h4000, 8'h00);
      push_access(KIND_READ,  16'h7FFF, 8'h00);
      push_access(KIND_READ,  16'h8000, 8'h00);
      push_access(KIND_WRITE, 16'h0000, 8'hFF);
      push_access(KIND_WRITE, 16'h7FFF, 8'h55);
      push_access(KIND_WRITE, 16'h8000, 8'hAA);
      push_access(KIND_WRITE, ADDR_SLOT0, 8'hFF);
      push_access(KIND_WRITE, ADDR_SLOT1, 8'hAB);
      push_access(KIND_WRITE, ADDR_SLOT2, 8'h5A);
      push_access(KIND_READ,  16'h0200, 8'h00);
      push_access(KIND_READ,  16'h2000, 8'h00);
      push_access(KIND_READ,  16'h5000, 8'h00);
      push_access(KIND_READ,  16'h9000, 8'h00);
      push_access(KIND_WRITE, ADDR_CTRL, 8'h0C);
      push_access(KIND_WRITE, 16'h8001, 8'hC3);
      push_access(KIND_READ,  16'hBFFF, 8'h00);
      push_access(KIND_WRITE, ADDR_CTRL, 8'hF3);
      push_access(KIND_READ,  16'hA000, 8'h00);
      push_access(KIND_READ,  16'hC000, 8'h00);
      push_access(KIND_READ,  16'hDFFF, 8'h00);
      push_access(KIND_WRITE, 16'hE123, 8'h81);
      wait_until_drained();

      // each pass ends with a full drain, so the sender is held until nothing is in flight
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = (p == 0) ? 17 : (p == 1) ? 86 : 0;
         receiver_idle_pct = (p == 0) ? 86 : (p == 1) ? 17 : 0;
         for (int k = 0; k < 3; k++) begin
            set_bank_mask(masks[p * 3 + k]);
            repeat (WORDS_PER_SETTING) push_random_access();
            wait_until_drained();
         end
      end

      repeat (8) @(posedge clock);
      if (expected_accesses.size() != 0)
         report_mismatch("results never arrived", expected_accesses.size(), 0);
      $display("checked %0d result words from %0d reads and %0d writes", results_checked,
               n_reads, n_writes);
      $display("writes: %0d dropped, %0d to cart RAM, %0d mapper control; %0d mask settings",
               n_dropped, n_cart, n_ctrl, n_masks);
      if (mismatches == 0)
         $display("[banked_memory_mapper_unit] OK");
      else
         $display("[banked_memory_mapper_unit] ERROR");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timed out with %0d words unsent and %0d results outstanding",
               cpu_accesses_to_send.size(), expected_accesses.size());
      $display("[banked_memory_mapper_unit] ERROR");
      $finish;
   end
endmodule
